// File: src/rpl_pkg.sv
// Shared constants for the block RMS / peak level meter.
// No dependencies; used by block_rms_peak_level_top.
package rpl_pkg;

  // default field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_MODE = 1'b1;

  // level_mode codes
  localparam logic MODE_RMS  = 1'b0;
  localparam logic MODE_PEAK = 1'b1;

  localparam int BLOCK_SIZE_RST = 800;

endpackage

// File: src/rpl_divsqrt.sv
// Iterative divide-then-square-root engine: floor(sqrt(floor(dividend / divisor))).
// One shared subtract/compare unit, one bit per cycle. No package dependency.
module rpl_divsqrt #(
  parameter int SUM_BITS   = 51,
  parameter int COUNT_BITS = 20,
  parameter int OUT_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_BITS-1:0]   dividend_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [OUT_BITS-1:0]   root_o
);

  localparam int ROOT_BITS  = (SUM_BITS + 1) / 2;
  localparam int WORK_BITS  = 2 * ROOT_BITS;
  localparam int UW         = (COUNT_BITS + 1 > ROOT_BITS + 2) ? COUNT_BITS + 1 : ROOT_BITS + 2;
  localparam int STEP_BITS  = $clog2(WORK_BITS + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]            phase_q, phase_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [WORK_BITS-1:0]  work_q, work_d;
  logic [UW-1:0]         rem_q, rem_d;
  logic [ROOT_BITS-1:0]  root_q, root_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic                  done_q, done_d;

  // shared subtractor
  logic [UW-1:0] op_a, op_b;
  logic [UW:0]   diff;
  logic          ge;
  logic [UW-1:0] div_sh, sqrt_sh;

  always_comb begin
    div_sh  = {rem_q[UW-2:0], work_q[WORK_BITS-1]};
    sqrt_sh = {rem_q[UW-3:0], work_q[WORK_BITS-1 -: 2]};
    if (phase_q == PH_DIV) begin
      op_a = div_sh;
      op_b = UW'(div_q);
    end else begin
      op_a = sqrt_sh;
      op_b = UW'({root_q, 2'b01});
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[UW];
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    work_d  = work_q;
    rem_d   = rem_q;
    root_d  = root_q;
    div_d   = div_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_DIV;
          step_d  = STEP_BITS'(WORK_BITS);
          work_d  = WORK_BITS'(dividend_i);
          rem_d   = '0;
          div_d   = divisor_i;
        end
      end
      PH_DIV: begin
        // quotient bits shift in as dividend bits shift out
        rem_d  = ge ? diff[UW-1:0] : div_sh;
        work_d = {work_q[WORK_BITS-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == STEP_BITS'(1)) begin
          phase_d = PH_SQRT;
          step_d  = STEP_BITS'(ROOT_BITS);
          rem_d   = '0;
          root_d  = '0;
        end
      end
      PH_SQRT: begin
        rem_d  = ge ? diff[UW-1:0] : sqrt_sh;
        root_d = {root_q[ROOT_BITS-2:0], ge};
        work_d = {work_q[WORK_BITS-3:0], 2'b00};
        step_d = step_q - 1'b1;
        if (step_q == STEP_BITS'(1)) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[OUT_BITS-1:0];

endmodule

// File: src/block_rms_peak_level_top.sv
// Block RMS / peak level meter, top level.
// Depends on rpl_pkg and rpl_divsqrt.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, sample_i): one signed sample per
//   transaction. Output channel (out_valid_o/out_ready_i, level_o): one level
//   per completed block of block_size samples, nothing for other samples.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 block_size
//   (0 acts as 1), index 1 level_mode (0 RMS, 1 peak). Write only when idle.
// Sequence:
//   A sample passes through accept, square and accumulate steps before the
//   next is taken; in_ready_o is low during the square and accumulate steps.
//   The sample that closes a block in peak mode goes on to a put step to post
//   the level. In RMS mode it first waits for the divide and square root,
//   which share one subtractor and produce one bit per cycle, and then goes
//   to the put step.
// Reset: all running sums, peak and count cleared, block_size 800, RMS mode.
// Stall: the level sits in an output register; the next samples are still
//   taken, and only a further block end waits until that level is taken.
module block_rms_peak_level_top #(
  parameter int SAMPLE_BITS = rpl_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = rpl_pkg::COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [SAMPLE_BITS-1:0]         level_o,
  input  logic                           cfg_we_i,
  input  logic [rpl_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COUNT_BITS-1:0]          cfg_data_i
);

  localparam int SUM_RAW  = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  localparam int SUM_BITS = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int SQ_BITS  = 2 * SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [COUNT_BITS-1:0]         block_size_q;
  logic                          level_mode_q;
  logic [SUM_BITS-1:0]           sum_q, sum_d;
  logic [SAMPLE_BITS-1:0]        peak_q, peak_d;
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic [SAMPLE_BITS-1:0]        mag_q;
  logic [SQ_BITS-1:0]            sq_q;
  logic [SAMPLE_BITS-1:0]        res_q, res_d;
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        level_q;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_BITS:0]      sum_ext;
  logic [SUM_BITS-1:0]    sum_new;
  logic [SAMPLE_BITS-1:0] peak_new;
  logic [COUNT_BITS-1:0]  count_new;
  logic [COUNT_BITS-1:0]  size_eff;
  logic                   eng_start;
  logic                   eng_done;
  logic [SAMPLE_BITS-1:0] eng_root;
  logic                   put_ok;

  // most negative sample wraps to 2^(SAMPLE_BITS-1) as unsigned
  assign mag      = samp_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_q) : SAMPLE_BITS'(samp_q);
  assign sum_ext  = {1'b0, sum_q} + (SUM_BITS+1)'(sq_q);
  assign sum_new  = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
  assign peak_new = (mag_q > peak_q) ? mag_q : peak_q;
  assign count_new = count_q + 1'b1;
  assign size_eff = (block_size_q == '0) ? COUNT_BITS'(1) : block_size_q;
  assign put_ok   = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    peak_d    = peak_q;
    count_d   = count_q;
    res_d     = res_q;
    eng_start = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SQ;
      ST_SQ:   state_d = ST_ACC;
      ST_ACC: begin
        if (count_new >= size_eff) begin
          sum_d   = '0;
          peak_d  = '0;
          count_d = '0;
          if (level_mode_q == rpl_pkg::MODE_PEAK) begin
            res_d   = peak_new;
            state_d = ST_PUT;
          end else begin
            eng_start = 1'b1;
            state_d   = ST_ROOT;
          end
        end else begin
          sum_d   = sum_new;
          peak_d  = peak_new;
          count_d = count_new;
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (eng_done) begin
          res_d   = eng_root;
          state_d = ST_PUT;
        end
      end
      ST_PUT:  if (put_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      block_size_q <= COUNT_BITS'(rpl_pkg::BLOCK_SIZE_RST);
      level_mode_q <= rpl_pkg::MODE_RMS;
      sum_q        <= '0;
      peak_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      peak_q  <= peak_d;
      count_q <= count_d;
      if (state_q == ST_PUT && put_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpl_pkg::CFG_BLOCK_SIZE: block_size_q <= cfg_data_i;
          rpl_pkg::CFG_LEVEL_MODE: level_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) samp_q <= sample_i;
    if (state_q == ST_SQ) begin
      mag_q <= mag;
      sq_q  <= mag * mag;
    end
    res_q <= res_d;
    if (state_q == ST_PUT && put_ok) level_q <= res_q;
  end

  rpl_divsqrt #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS),
    .OUT_BITS   (SAMPLE_BITS)
  ) u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eng_start),
    .dividend_i (sum_new),
    .divisor_i  (size_eff),
    .done_o     (eng_done),
    .root_o     (eng_root)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule
